>>> hdl/rotary_detent_step_tracker_macros.svh
// assertion helpers for the rotary detent step tracker
`ifndef ROTARY_DETENT_STEP_TRACKER_MACROS_SVH
`define ROTARY_DETENT_STEP_TRACKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RDST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define RDST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rdst_pkg.sv
package rdst_pkg;

  // field widths
  localparam int RAW_W      = 16;
  localparam int POS_W      = 32;
  localparam int THR_W      = 8;
  localparam int TMO_W      = 16;
  localparam int RES_W      = 9;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // divider sizing: magnitude of the negated sample needs one extra bit
  localparam int MAG_W     = RAW_W + 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int Q_W       = MAG_W + 1;
  localparam int SUM_W     = RES_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUE_TIMEOUT = 1'b1;

  // register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd2;
  localparam logic [TMO_W-1:0] TIMEOUT_RST   = 16'd200;

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [RAW_W-1:0] raw_count;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] change;
    logic                    changed;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic sum;
    logic adj;
    logic commit;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_query;
  } stat_t;

endpackage

>>> hdl/rdst_ctrl.sv
module rdst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rdst_pkg::stat_t stat,
  output rdst_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_SUM,
    S_ADJ,
    S_COMMIT,
    S_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [rdst_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       cnt_last;

  assign cnt_last  = (cnt_r == rdst_pkg::CNT_W'(rdst_pkg::DIV_STEPS - 1));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_nxt   = '0;
        state_nxt = stat.is_query ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_SUM;
        end else begin
          cnt_nxt = cnt_r + rdst_pkg::CNT_W'(1);
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.adj   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/rdst_dp.sv
module rdst_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rdst_pkg::in_item_t                   in_data,
  input  logic                                 cfg_we,
  input  logic [rdst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdst_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  rdst_pkg::cmd_t                       cmd,
  output rdst_pkg::stat_t                      stat,
  output rdst_pkg::out_item_t                  out_data
);

  // configuration
  logic [rdst_pkg::THR_W-1:0] thr_r;
  logic [rdst_pkg::TMO_W-1:0] tmo_r;
  logic [rdst_pkg::THR_W-1:0] thr_eff;

  // per-item working registers
  logic                              kind_r;
  logic                              neg_r;
  logic [rdst_pkg::MAG_W-1:0]        quo_r;
  logic [rdst_pkg::THR_W-1:0]        rem_r;
  logic signed [rdst_pkg::Q_W-1:0]   q_r;
  logic signed [rdst_pkg::SUM_W-1:0] res_sum_r;
  logic signed [rdst_pkg::RES_W-1:0] res_adj_r;
  logic [rdst_pkg::POS_W-1:0]        diff_r;

  // tracker state
  logic [rdst_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [rdst_pkg::POS_W-1:0]        pend_r, pend_nxt;
  logic                              latch_r, latch_nxt;
  logic [rdst_pkg::TMO_W-1:0]        idle_r, idle_nxt;
  logic signed [rdst_pkg::RES_W-1:0] residue_r, residue_nxt;

  rdst_pkg::out_item_t out_r;

  // sample magnitude and sign of the negated count
  logic                       raw_neg;
  logic                       samp_neg;
  logic [rdst_pkg::MAG_W-1:0] mag;

  // divider step
  logic [rdst_pkg::THR_W:0]   trial;
  logic [rdst_pkg::THR_W:0]   trial_sub;
  logic                       fits;

  // signed quotient and remainder
  logic signed [rdst_pkg::Q_W-1:0]   q_sig;
  logic signed [rdst_pkg::SUM_W-1:0] r_sig;
  logic signed [rdst_pkg::SUM_W-1:0] res_sum;

  // residue folding
  logic signed [rdst_pkg::SUM_W-1:0] thr_s;
  logic signed [rdst_pkg::SUM_W-1:0] thr_neg;
  logic signed [rdst_pkg::SUM_W-1:0] res_adj;
  logic signed [rdst_pkg::Q_W-1:0]   adj;
  logic signed [rdst_pkg::Q_W-1:0]   step_q;

  logic [rdst_pkg::TMO_W:0] idle_inc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rdst_pkg::THRESHOLD_RST;
      tmo_r <= rdst_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rdst_pkg::REG_STEP_THRESHOLD:  thr_r <= cfg_wdata[rdst_pkg::THR_W-1:0];
        rdst_pkg::REG_RESIDUE_TIMEOUT: tmo_r <= cfg_wdata[rdst_pkg::TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a zero threshold behaves as one
  assign thr_eff = (thr_r == '0) ? rdst_pkg::THR_W'(1) : thr_r;

  // |s| equals |raw_count|; s is negative when raw_count is positive
  assign raw_neg  = in_data.raw_count[rdst_pkg::RAW_W-1];
  assign samp_neg = !raw_neg && (in_data.raw_count != '0);
  assign mag      = raw_neg ? (rdst_pkg::MAG_W'(0) - {raw_neg, in_data.raw_count})
                            : {1'b0, in_data.raw_count};

  // restoring divide, one quotient bit per step
  assign trial     = {rem_r, quo_r[rdst_pkg::MAG_W-1]};
  assign trial_sub = trial - {1'b0, thr_eff};
  assign fits      = (trial >= {1'b0, thr_eff});

  // apply sign of the sample to quotient and remainder
  assign q_sig   = neg_r ? (rdst_pkg::Q_W'(0) - {1'b0, quo_r}) : {1'b0, quo_r};
  assign r_sig   = neg_r ? (rdst_pkg::SUM_W'(0) - rdst_pkg::SUM_W'(rem_r))
                         : rdst_pkg::SUM_W'(rem_r);
  assign res_sum = {residue_r[rdst_pkg::RES_W-1], residue_r} + r_sig;

  // residue reaching plus or minus the threshold moves one step into the position
  assign thr_s   = {{(rdst_pkg::SUM_W - rdst_pkg::THR_W){1'b0}}, thr_eff};
  assign thr_neg = rdst_pkg::SUM_W'(0) - thr_s;

  always_comb begin
    if (res_sum_r >= thr_s) begin
      res_adj = res_sum_r - thr_s;
      adj     = rdst_pkg::Q_W'(1);
    end else if (res_sum_r <= thr_neg) begin
      res_adj = res_sum_r + thr_s;
      adj     = '1;
    end else begin
      res_adj = res_sum_r;
      adj     = '0;
    end
  end

  assign step_q = q_r + adj;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_data.kind;
      neg_r  <= samp_neg;
      quo_r  <= mag;
      rem_r  <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[rdst_pkg::MAG_W-2:0], fits};
      rem_r <= fits ? trial_sub[rdst_pkg::THR_W-1:0] : trial[rdst_pkg::THR_W-1:0];
    end
    if (cmd.sum) begin
      q_r       <= q_sig;
      res_sum_r <= res_sum;
    end
    if (cmd.adj) begin
      res_adj_r <= res_adj[rdst_pkg::RES_W-1:0];
      diff_r    <= {{(rdst_pkg::POS_W - rdst_pkg::Q_W){step_q[rdst_pkg::Q_W-1]}}, step_q};
    end
  end

  assign idle_inc = {1'b0, idle_r} + (rdst_pkg::TMO_W + 1)'(1);

  // tracker state update
  always_comb begin
    pos_nxt     = pos_r;
    pend_nxt    = pend_r;
    latch_nxt   = latch_r;
    idle_nxt    = idle_r;
    residue_nxt = residue_r;
    if (cmd.commit) begin
      pos_nxt = pos_r + diff_r;
      if (diff_r != '0) begin
        latch_nxt = 1'b1;
        pend_nxt  = latch_r ? (pend_r + diff_r) : diff_r;
      end else if (!latch_r) begin
        pend_nxt = '0;
      end
      // residue timeout
      if (res_adj_r != '0) begin
        if (idle_inc > {1'b0, tmo_r}) begin
          idle_nxt    = '0;
          residue_nxt = '0;
        end else begin
          idle_nxt    = idle_inc[rdst_pkg::TMO_W-1:0];
          residue_nxt = res_adj_r;
        end
      end else begin
        idle_nxt    = '0;
        residue_nxt = res_adj_r;
      end
    end
    // a query releases the change latch
    if (cmd.emit && (kind_r == rdst_pkg::KIND_QUERY)) begin
      latch_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pend_r    <= '0;
      latch_r   <= 1'b0;
      idle_r    <= '0;
      residue_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      pend_r    <= pend_nxt;
      latch_r   <= latch_nxt;
      idle_r    <= idle_nxt;
      residue_r <= residue_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.position <= pos_r;
      out_r.change   <= pend_r;
      out_r.changed  <= (kind_r == rdst_pkg::KIND_QUERY) && (pend_r != '0);
    end
  end

  assign out_data      = out_r;
  assign stat.is_query = (kind_r == rdst_pkg::KIND_QUERY);

endmodule

>>> hdl/rotary_detent_step_tracker.sv
// Rotary detent step tracker.
// Input channel (in_valid/in_ready/in_data) takes one item per transfer: a tick
// carrying a signed raw count delta, or a change query. Every item yields one
// result on the output channel (out_valid/out_ready/out_data) with the step
// position, the pending change and, for a query, whether that change is nonzero.
// A tick passes from its input transfer through a decode step, 17 iterations
// of the bit-serial signed divider by the step threshold, residue folding and
// the state update, and a load of the result register that raises out_valid.
// A query goes from decode straight to the result load. One item is processed
// at a time: in_ready is high only while idle, so a new item is accepted only
// after the previous one has been loaded into the result register.
// The result register decouples the channels: the next item is accepted while a
// result still waits, and processing stalls before its result load until the
// receiver has taken the previous one.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes the step threshold or the
// residue timeout, as cfg_index selects; write only while no item is in flight.
// Synchronous reset clears position, change, residue and idle count, restores
// threshold 2 and timeout 200, and drops out_valid.
`include "rotary_detent_step_tracker_macros.svh"

module rotary_detent_step_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rdst_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rdst_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rdst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdst_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rdst_pkg::cmd_t  cmd;
  rdst_pkg::stat_t stat;

  // sequencing
  rdst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // divider, state and result register
  rdst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // checks
  `RDST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted item while busy")
  `RDST_ASSERT_NOW(a_emit_slot_free, cmd.emit, !out_valid || out_ready, "result overwritten")
  `RDST_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "result not presented")

endmodule
